### rtl/instruction_mix_performance_counters_unit_macros.svh
// Assertion helpers used by the counter unit.
`ifndef INSTRUCTION_MIX_PERFORMANCE_COUNTERS_UNIT_MACROS_SVH
`define INSTRUCTION_MIX_PERFORMANCE_COUNTERS_UNIT_MACROS_SVH

// Check on every rising clock edge while out of reset.
`define IMCU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every rising clock edge, reset included.
`define IMCU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/imcu_pkg.sv
`timescale 1ns / 1ps
package imcu_pkg;

  localparam int unsigned CounterWidth = 64;
  localparam int unsigned NumCounters  = 18;
  localparam int unsigned SelWidth     = 5;
  localparam int unsigned ValueWidth   = 64;

  // Counter order as seen by a read, cycles first.
  localparam int unsigned CntCycles     = 0;
  localparam int unsigned CntInsts      = 1;
  localparam int unsigned CntPredOk     = 2;
  localparam int unsigned CntPredAll    = 3;
  localparam int unsigned CntNop        = 4;
  localparam int unsigned CntBubble     = 5;
  localparam int unsigned CntLdSt       = 6;
  localparam int unsigned CntArith      = 7;
  localparam int unsigned CntBranch     = 8;
  localparam int unsigned CntJump       = 9;
  localparam int unsigned CntMisc       = 10;
  localparam int unsigned CntLoad       = 11;
  localparam int unsigned CntStore      = 12;
  localparam int unsigned CntOrderFail  = 13;
  localparam int unsigned CntSleep      = 14;
  localparam int unsigned CntKilled     = 15;
  localparam int unsigned CntForwarded  = 16;
  localparam int unsigned CntLsuMisc    = 17;

  localparam logic [31:0] WordNop    = 32'h0000_0013;
  localparam logic [31:0] WordBubble = 32'h0000_0233;
  localparam logic [6:0]  OpLui      = 7'h37;
  localparam logic [6:0]  OpBranch   = 7'h63;
  localparam logic [6:0]  OpJalr     = 7'h67;
  localparam logic [6:0]  OpJumpAlt  = 7'h6b;
  localparam logic [6:0]  OpJal      = 7'h6f;
  localparam logic [6:0]  OpLoad     = 7'h03;
  localparam logic [6:0]  OpStore    = 7'h23;
  localparam logic [2:0]  Low3OpReg  = 3'h6;
  localparam logic [2:0]  Low3OpImm  = 3'h4;

  typedef enum logic [1:0] {
    KindTick  = 2'd0,
    KindStart = 2'd1,
    KindStop  = 2'd2,
    KindRead  = 2'd3
  } kind_e;

  typedef logic [CounterWidth-1:0] counter_t;

  // One-hot instruction class.
  typedef struct packed {
    logic nop;
    logic bubble;
    logic load;
    logic store;
    logic branch;
    logic jump;
    logic arith;
    logic misc;
  } inst_class_t;

  // Update request handed to the counter bank, one per cycle.
  typedef struct packed {
    logic        start;
    logic        stop;
    logic        tick;
    logic        count_inst;
    inst_class_t cls;
    logic        pred_ok;
    logic        pred_res;
    logic        order_fail;
    logic        killed;
    logic        forwarded;
  } bank_evt_t;

  function automatic inst_class_t classify(input logic [31:0] word);
    inst_class_t c;
    logic [6:0]  op;
    logic [2:0]  low3;
    c    = '0;
    op   = word[6:0];
    low3 = word[4:2];
    if (word == WordNop) begin
      c.nop = 1'b1;
    end else if (word == WordBubble) begin
      c.bubble = 1'b1;
    end else if (op == OpLui) begin
      c.misc = 1'b1;
    end else if (op == OpBranch) begin
      c.branch = 1'b1;
    end else if (op == OpJalr || op == OpJumpAlt || op == OpJal) begin
      c.jump = 1'b1;
    end else if (op == OpLoad) begin
      c.load = 1'b1;
    end else if (op == OpStore) begin
      c.store = 1'b1;
    end else if (low3 == Low3OpReg || low3 == Low3OpImm) begin
      c.arith = 1'b1;
    end else begin
      c.misc = 1'b1;
    end
    return c;
  endfunction

endpackage

### rtl/imcu_counter_bank.sv
`timescale 1ns / 1ps
module imcu_counter_bank
  import imcu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bank_evt_t           evt_i,
  input  logic [SelWidth-1:0] rd_sel_i,
  output counter_t            rd_value_o
);

  counter_t                cnt_q [NumCounters];
  counter_t                cnt_d [NumCounters];
  logic [NumCounters-1:0]  inc;
  logic                    halted_q, halted_d;
  logic                    run;

  always_comb begin
    run = evt_i.tick & ~halted_q;
    inc = '0;
    inc[CntCycles]    = run;
    inc[CntInsts]     = run & evt_i.count_inst & ~evt_i.cls.bubble;
    inc[CntPredOk]    = run & evt_i.pred_ok;
    inc[CntPredAll]   = run & evt_i.pred_res;
    inc[CntNop]       = run & evt_i.count_inst & evt_i.cls.nop;
    inc[CntBubble]    = run & evt_i.count_inst & evt_i.cls.bubble;
    inc[CntLdSt]      = run & evt_i.count_inst & (evt_i.cls.load | evt_i.cls.store);
    inc[CntArith]     = run & evt_i.count_inst & evt_i.cls.arith;
    inc[CntBranch]    = run & evt_i.count_inst & evt_i.cls.branch;
    inc[CntJump]      = run & evt_i.count_inst & evt_i.cls.jump;
    inc[CntMisc]      = run & evt_i.count_inst & evt_i.cls.misc;
    inc[CntLoad]      = run & evt_i.count_inst & evt_i.cls.load;
    inc[CntStore]     = run & evt_i.count_inst & evt_i.cls.store;
    inc[CntOrderFail] = run & evt_i.order_fail;
    inc[CntKilled]    = run & evt_i.killed;
    inc[CntForwarded] = run & evt_i.forwarded;
    inc[CntLsuMisc]   = run & evt_i.killed;

    for (int i = 0; i < NumCounters; i++) begin
      cnt_d[i] = cnt_q[i] + counter_t'(inc[i]);
    end
    // Sleep takes killed (after this bump) minus forwarded (before this bump).
    if (run && evt_i.killed) begin
      cnt_d[CntSleep] = cnt_q[CntKilled] + counter_t'(1) - cnt_q[CntForwarded];
    end
    if (evt_i.start) begin
      for (int i = 0; i < NumCounters; i++) begin
        cnt_d[i] = '0;
      end
    end

    halted_d = halted_q;
    if (evt_i.start) begin
      halted_d = 1'b0;
    end else if (evt_i.stop) begin
      halted_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b1;
      for (int i = 0; i < NumCounters; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      halted_q <= halted_d;
      for (int i = 0; i < NumCounters; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  // Out-of-range selects read as zero.
  always_comb begin
    rd_value_o = '0;
    for (int i = 0; i < NumCounters; i++) begin
      if (rd_sel_i == SelWidth'(i)) begin
        rd_value_o = cnt_q[i];
      end
    end
  end

endmodule

### rtl/instruction_mix_performance_counters_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Signals                      Content
// s_axis    in   tvalid/tready/tdata/tuser    one item: tick, start, stop or read
// m_axis    out  tvalid/tready/tdata          one result per read: id and value
//
// Each accepted transfer lands in the input register; from there it is applied
// to the counter bank and, for a read, captured in the output register.
// Sustained rate is one transfer per cycle while m_axis takes results; a read result
// is valid on m_axis once it has passed the input and output registers. The input
// side stalls only while a read sits in the input register and the output register
// still holds an untaken result.
// Reset leaves all counters at zero and the bank paused.
`include "instruction_mix_performance_counters_unit_macros.svh"
module instruction_mix_performance_counters_unit
  import imcu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] instruction, [32] count_instruction, [33] prediction_correct,
  // [34] prediction_resolved, [35] load_order_fail, [36] load_killed,
  // [37] load_forwarded, [42:38] counter_select, [47:43] zero
  input  logic [47:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] counter_id, [68:5] counter_value, [71:69] zero
  output logic [71:0] m_axis_tdata
);

  // Input register.
  logic                in_valid_q, in_valid_d;
  kind_e               kind_q;
  logic [31:0]         word_q;
  logic                count_q, pred_ok_q, pred_res_q;
  logic                order_fail_q, killed_q, forwarded_q;
  logic [SelWidth-1:0] sel_q;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic [SelWidth-1:0]   out_id_q;
  logic [ValueWidth-1:0] out_value_q;

  logic      s_fire;
  logic      consume;
  logic      is_read;
  bank_evt_t evt;
  counter_t  rd_value;

  assign is_read = (kind_q == KindRead);
  // A read advances only when the output register is free or being drained.
  assign consume = in_valid_q & (~is_read | ~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | consume;
  assign s_fire = s_axis_tvalid & s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (consume && is_read) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Raise the bank's start, stop and tick only when the held item is applied.
  always_comb begin
    evt            = '0;
    evt.start      = consume & (kind_q == KindStart);
    evt.stop       = consume & (kind_q == KindStop);
    evt.tick       = consume & (kind_q == KindTick);
    evt.count_inst = count_q;
    evt.cls        = classify(word_q);
    evt.pred_ok    = pred_ok_q;
    evt.pred_res   = pred_res_q;
    evt.order_fail = order_fail_q;
    evt.killed     = killed_q;
    evt.forwarded  = forwarded_q;
  end

  imcu_counter_bank u_bank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_i      (evt),
    .rd_sel_i   (sel_q),
    .rd_value_o (rd_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: capture on transfer, hold otherwise; a read result is captured when its read is applied.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      kind_q       <= kind_e'(s_axis_tuser);
      word_q       <= s_axis_tdata[31:0];
      count_q      <= s_axis_tdata[32];
      pred_ok_q    <= s_axis_tdata[33];
      pred_res_q   <= s_axis_tdata[34];
      order_fail_q <= s_axis_tdata[35];
      killed_q     <= s_axis_tdata[36];
      forwarded_q  <= s_axis_tdata[37];
      sel_q        <= s_axis_tdata[42:38];
    end
    if (consume && is_read) begin
      out_id_q    <= sel_q;
      out_value_q <= ValueWidth'(rd_value);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_value_q, out_id_q};

  `IMCU_ASSERT(a_read_gives_result, (consume && is_read) |=> out_valid_q, "read lost")
  `IMCU_ASSERT(a_no_result_from_ctrl,
    (consume && !is_read && !out_valid_q) |=> !out_valid_q, "result without read")
  `IMCU_ASSERT(a_stall_only_on_read, !s_axis_tready |-> (in_valid_q && is_read),
    "input stalled without a pending read")
  `IMCU_ASSERT(a_out_of_range_zero,
    (out_valid_q && out_id_q >= SelWidth'(NumCounters)) |-> (out_value_q == '0),
    "out-of-range select returned nonzero")

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import imcu_pkg::*;

  // One item as seen on the slave side.
  typedef struct {
    kind_e       kind;
    logic [31:0] instruction;
    logic        count_instruction;
    logic        prediction_correct;
    logic        prediction_resolved;
    logic        load_order_fail;
    logic        load_killed;
    logic        load_forwarded;
    logic [4:0]  counter_select;
  } perf_item_t;

  // One read result as seen on the master side.
  typedef struct {
    logic [4:0]  counter_id;
    logic [63:0] counter_value;
  } counter_read_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;

  // Shadow of the counter bank, updated on every accepted transfer.
  counter_t      shadow_bank [NumCounters];
  logic          shadow_halted;
  counter_read_t pending_reads[$];

  int unsigned mismatch_count;
  int unsigned src_gap_pct;
  int unsigned sink_stall_pct;

  instruction_mix_performance_counters_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #1000000;
    $display("instruction_mix_performance_counters_unit: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void bump_shadow(int unsigned idx);
    shadow_bank[idx] = shadow_bank[idx] + 1'b1;
  endfunction

  // Sort one instruction word into exactly one class.
  function automatic void count_class(logic [31:0] word);
    logic [6:0] opcode;
    logic [2:0] low3;
    opcode = word[6:0];
    low3   = word[4:2];
    if (word == WordNop) begin
      bump_shadow(CntNop);
    end else if (word == WordBubble) begin
      bump_shadow(CntBubble);
    end else if (opcode == OpLui) begin
      bump_shadow(CntMisc);
    end else if (opcode == OpBranch) begin
      bump_shadow(CntBranch);
    end else if (opcode == OpJalr || opcode == OpJumpAlt || opcode == OpJal) begin
      bump_shadow(CntJump);
    end else if (opcode == OpLoad) begin
      bump_shadow(CntLoad);
      bump_shadow(CntLdSt);
    end else if (opcode == OpStore) begin
      bump_shadow(CntStore);
      bump_shadow(CntLdSt);
    end else if (low3 == Low3OpReg || low3 == Low3OpImm) begin
      bump_shadow(CntArith);
    end else begin
      bump_shadow(CntMisc);
    end
  endfunction

  // Apply one accepted item to the shadow bank; queue the result of a read.
  function automatic void predict_counters(perf_item_t it);
    counter_read_t rd;
    case (it.kind)
      KindStart: begin
        foreach (shadow_bank[i]) shadow_bank[i] = '0;
        shadow_halted = 1'b0;
      end
      KindStop: shadow_halted = 1'b1;
      KindRead: begin
        rd.counter_id    = it.counter_select;
        rd.counter_value = (it.counter_select < NumCounters) ?
                           shadow_bank[it.counter_select] : '0;
        pending_reads.push_back(rd);
      end
      default: begin
        if (!shadow_halted) begin
          bump_shadow(CntCycles);
          if (it.count_instruction && it.instruction != WordBubble) bump_shadow(CntInsts);
          if (it.prediction_correct) bump_shadow(CntPredOk);
          if (it.prediction_resolved) bump_shadow(CntPredAll);
          if (it.count_instruction) count_class(it.instruction);
          if (it.load_order_fail) bump_shadow(CntOrderFail);
          // Put-to-sleep uses the forward count from before this cycle's forward.
          if (it.load_killed) begin
            bump_shadow(CntKilled);
            shadow_bank[CntSleep] = shadow_bank[CntKilled] - shadow_bank[CntForwarded];
            bump_shadow(CntLsuMisc);
          end
          if (it.load_forwarded) bump_shadow(CntForwarded);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    counter_read_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected result transfer: counter_id %0d counter_value %0h",
               m_axis_tdata[4:0], m_axis_tdata[68:5]);
        mismatch_count++;
      end else begin
        want = pending_reads.pop_front();
        if (m_axis_tdata[4:0] !== want.counter_id) begin
          $error("counter_id: expected %0d, got %0d", want.counter_id, m_axis_tdata[4:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[68:5] !== want.counter_value) begin
          $error("counter_value: expected %0h, got %0h (counter %0d)",
                 want.counter_value, m_axis_tdata[68:5], want.counter_id);
          mismatch_count++;
        end
      end
    end
  end

  // Result side back-pressure: random stall bursts, drawn at sink_stall_pct.
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic perf_item_t tick_item(logic [31:0] word, logic count, logic pok,
                                           logic pres, logic ofail, logic killed,
                                           logic fwd);
    perf_item_t it;
    it.kind                = KindTick;
    it.instruction         = word;
    it.count_instruction   = count;
    it.prediction_correct  = pok;
    it.prediction_resolved = pres;
    it.load_order_fail     = ofail;
    it.load_killed         = killed;
    it.load_forwarded      = fwd;
    it.counter_select      = 5'($urandom_range(0, 31));
    return it;
  endfunction

  // Start, stop or read; the tick fields carry noise the block must ignore.
  function automatic perf_item_t control_item(kind_e kind, logic [4:0] sel);
    perf_item_t it;
    logic [5:0] noise;
    noise = 6'($urandom);
    it = tick_item($urandom, noise[0], noise[1], noise[2], noise[3], noise[4], noise[5]);
    it.kind           = kind;
    it.counter_select = sel;
    return it;
  endfunction

  // Instruction word biased toward every class, with random upper bits.
  function automatic logic [31:0] pick_instruction();
    logic [31:0] word;
    word = $urandom;
    case ($urandom_range(0, 11))
      0:  word = WordNop;
      1:  word = WordBubble;
      2:  word[6:0] = OpLui;
      3:  word[6:0] = OpBranch;
      4:  word[6:0] = OpJalr;
      5:  word[6:0] = OpJumpAlt;
      6:  word[6:0] = OpJal;
      7:  word[6:0] = OpLoad;
      8:  word[6:0] = OpStore;
      9:  word[4:2] = Low3OpReg;
      10: word[4:2] = Low3OpImm;
      default: ;
    endcase
    return word;
  endfunction

  // Drive one item and hold it until the block takes the transfer.
  task automatic send_item(perf_item_t it);
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {5'b0, it.counter_select, it.load_forwarded, it.load_killed,
                      it.load_order_fail, it.prediction_resolved, it.prediction_correct,
                      it.count_instruction, it.instruction};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_counters(it);
  endtask

  // Hold the input side until every queued read has returned.
  task automatic drain_reads();
    s_axis_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset the bank is paused and zero; out-of-range selects read zero.
  task automatic test_reset_state();
    send_item(tick_item(WordNop, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    send_item(control_item(KindRead, 5'(CntCycles)));
    send_item(control_item(KindRead, 5'd31));
  endtask

  // Walk every instruction class and every event flag at least once.
  task automatic test_instruction_classes();
    send_item(control_item(KindStart, '0));
    send_item(tick_item(WordNop,       1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(tick_item(WordBubble,    1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    // a bubble word that is not counted only adds a cycle
    send_item(tick_item(WordBubble,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(tick_item(32'hffff_f037, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(tick_item(32'h8000_0063, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(tick_item(32'h0000_0067, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(tick_item(32'h0000_006b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(tick_item(32'h0000_006f, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    // forwards ahead of any kill make put-to-sleep wrap below zero
    send_item(tick_item(32'h0000_0003, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(tick_item(32'h0000_0023, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(tick_item(32'h0000_0033, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(tick_item(32'h0000_003b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(tick_item(32'hffff_ffff, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
    // kill and forward together: the forward lands after put-to-sleep
    send_item(tick_item(32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
    send_item(control_item(KindStop, '0));
    send_item(tick_item(WordNop, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    send_item(control_item(KindRead, 5'(CntCycles)));
    send_item(control_item(KindRead, 5'(CntSleep)));
    send_item(control_item(KindRead, 5'(CntJump)));
  endtask

  // Mostly ticks with random content, reads of every counter, and the odd
  // start or stop; the idle rate is re-rolled now and then so that some
  // stretches run without gaps.
  task automatic test_random_traffic(int unsigned n_items, int unsigned gap_pct,
                                     int unsigned stall_pct);
    int unsigned roll;
    logic [5:0]  flags;
    send_item(control_item(KindStart, '0));
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 64 == 0) begin
        src_gap_pct    = ($urandom_range(0, 3) == 0) ? 0 : gap_pct;
        sink_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : stall_pct;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        send_item(control_item(KindStart, 5'($urandom)));
      end else if (roll < 4) begin
        send_item(control_item(KindStop, 5'($urandom)));
      end else if (roll < 22) begin
        send_item(control_item(KindRead, ($urandom_range(0, 6) == 0) ?
                                         5'($urandom_range(NumCounters, 31)) :
                                         5'($urandom_range(0, NumCounters - 1))));
      end else begin
        flags = 6'($urandom);
        send_item(tick_item(pick_instruction(), $urandom_range(0, 3) != 0, flags[0],
                            flags[1], flags[2], flags[3], flags[4]));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    mismatch_count = 0;
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    foreach (shadow_bank[i]) shadow_bank[i] = '0;
    shadow_halted = 1'b1;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KindTick;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_instruction_classes();
    test_random_traffic(800, 15, 15);
    drain_reads();
    test_random_traffic(600, 40, 40);
    drain_reads();
    // closing stretch runs at full rate on both sides
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    test_random_traffic(400, 0, 0);

    s_axis_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("instruction_mix_performance_counters_unit: match");
    end else begin
      $display("instruction_mix_performance_counters_unit: mismatch");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/imcu_pkg.sv
rtl/imcu_counter_bank.sv
rtl/instruction_mix_performance_counters_unit.sv
tb/sv/tb.sv
